// ===== design/fsbp_pkg.sv =====
// shared types and constants of the fetch stage with branch target buffer
// used by every module of the fetch stage; depends on nothing else
package fsbp_pkg;

	// widths of the address and word fields
	localparam int PC_W   = 10;
	localparam int WORD_W = 32;
	localparam int LEN_W  = 11;

	// all-ones fetch address reported with an invalid result
	localparam logic [PC_W-1:0] PC_ALL_ONES = 10'h3FF;

	// opcode field of an instruction word
	localparam int OPC_LSB = 26;
	localparam int OPC_W   = 6;
	localparam logic [OPC_W-1:0] OP_BEQ = 6'd4;

	// item kinds carried on s_tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam logic REG_PROGRAM_LENGTH = 1'b0;

	// input item payload, last field in the lowest bits
	typedef struct packed {
		logic [6:0]        pad;
		logic [PC_W-1:0]   jump_target;
		logic              jump_valid;
		logic              resolve_taken;
		logic [PC_W-1:0]   resolve_pc;
		logic              resolve_valid;
		logic [WORD_W-1:0] load_word;
		logic [PC_W-1:0]   load_addr;
	} in_item_t;

	// result item payload, last field in the lowest bits
	typedef struct packed {
		logic [5:0]        pad;
		logic [WORD_W-1:0] instruction;
		logic [PC_W-1:0]   fetched_pc;
	} out_item_t;

	localparam int S_TDATA_W = $bits(in_item_t);
	localparam int M_TDATA_W = $bits(out_item_t);

	// control from the fetch pipeline to the branch target buffer
	typedef struct packed {
		logic rd_a_en;
		logic rd_b_en;
		logic flip_en;
		logic flip_taken;
		logic ins_en;
	} btb_ctl_t;

endpackage

// ===== design/fsbp_imem.sv =====
// program store: one write port and one registered read port
// depends on fsbp_pkg for the word width
module fsbp_imem #(
	parameter int DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  logic [fsbp_pkg::WORD_W-1:0]  wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic [fsbp_pkg::WORD_W-1:0]  rd_data
);

	logic [fsbp_pkg::WORD_W-1:0] mem [DEPTH];

	// synchronous write and read, read data held until the next read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/fsbp_btb.sv =====
// direct-mapped branch target buffer: target memory plus valid and prediction bits
// depends on fsbp_pkg for the address width and the control struct
module fsbp_btb #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fsbp_pkg::btb_ctl_t            ctl,
	input  logic [$clog2(ENTRIES)-1:0]    ra_idx,
	input  logic [$clog2(ENTRIES)-1:0]    rb_idx,
	input  logic [$clog2(ENTRIES)-1:0]    r_idx,
	input  logic [$clog2(ENTRIES)-1:0]    f_idx,
	input  logic [fsbp_pkg::PC_W-1:0]     ins_tgt,
	output logic [fsbp_pkg::PC_W-1:0]     ra_tgt,
	output logic [fsbp_pkg::PC_W-1:0]     rb_tgt,
	output logic                          r_valid,
	output logic                          r_pred,
	output logic                          f_valid,
	output logic                          f_pred
);

	logic [ENTRIES-1:0]          valid_q;
	logic [ENTRIES-1:0]          pred_q;
	logic [fsbp_pkg::PC_W-1:0]   tgt_mem [ENTRIES];

	// valid and prediction bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pred_q  <= '0;
		end else begin
			if (ctl.flip_en) begin
				pred_q[r_idx] <= ctl.flip_taken;
			end
			if (ctl.ins_en) begin
				valid_q[f_idx] <= 1'b1;
				pred_q[f_idx]  <= 1'b0;
			end
		end
	end

	// target memory; port a forwards an install made at the same edge
	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			tgt_mem[f_idx] <= ins_tgt;
		end
		if (ctl.rd_a_en) begin
			ra_tgt <= (ctl.ins_en && f_idx == ra_idx) ? ins_tgt : tgt_mem[ra_idx];
		end
		if (ctl.rd_b_en) begin
			rb_tgt <= tgt_mem[rb_idx];
		end
	end

	assign r_valid = valid_q[r_idx];
	assign r_pred  = pred_q[r_idx];
	assign f_valid = valid_q[f_idx];
	assign f_pred  = pred_q[f_idx];

endmodule

// ===== design/fsbp_cfg.sv =====
// configuration register block behind the apb-style port
// depends on fsbp_pkg for the register index and widths
module fsbp_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fsbp_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output logic [fsbp_pkg::LEN_W-1:0]         program_length
);

	logic                          wr_hit;
	logic [fsbp_pkg::LEN_W-1:0]    len_q;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && pready
		&& (paddr[fsbp_pkg::CFG_ADDR_W-1] == fsbp_pkg::REG_PROGRAM_LENGTH);

	// program length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (wr_hit) begin
			len_q <= pwdata[fsbp_pkg::LEN_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (paddr[fsbp_pkg::CFG_ADDR_W-1] == fsbp_pkg::REG_PROGRAM_LENGTH) begin
			prdata = 32'(len_q);
		end
	end

	assign program_length = len_q;

endmodule

// ===== design/fetch_stage_with_btb_predictor_core.sv =====
// top level of the instruction fetch stage with direct-mapped btb and one-bit predictor
// depends on fsbp_pkg, fsbp_imem, fsbp_btb and fsbp_cfg
//
// usage
// - the apb-style port sets program_length (addresses 0 to 3); write it only while idle
// - s_tuser 0 is a load item: its word is written to the program store and the
//   fetch address rewinds to 0; it gives no result
// - s_tuser 1 is a fetch item: it gives exactly one result item on the m_ group,
//   m_tuser high for a fetched word, low once the program has ended
// - a fetch item is accepted, picks its address in the next cycle while the
//   program store is read, and its result is registered from stage 2 into the
//   output register, where stage 2 waits while a held result is not yet taken
// - no item is taken while a fetch item is in stage 1, as the next address
//   needs the word just read from the program store and its btb entry
// - a result waits in the output register while m_tready is low; one more item
//   can be accepted and held behind it
// - reset clears the fetch address, the halt flag, program_length and all btb
//   valid and prediction bits; the program store is undefined until loaded
module fetch_stage_with_btb_predictor_core #(
	parameter int IMEM_DEPTH  = 1024,
	parameter int BTB_ENTRIES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [fsbp_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// load_addr, load_word, resolve_valid, resolve_pc, resolve_taken,
	// jump_valid, jump_target, zero fill
	input  logic [fsbp_pkg::S_TDATA_W-1:0]       s_tdata,
	// req_type
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// fetched_pc, instruction, zero fill
	output logic [fsbp_pkg::M_TDATA_W-1:0]       m_tdata,
	// fetch_valid
	output logic                                 m_tuser
);

	localparam int AW = $clog2(IMEM_DEPTH);
	localparam int IW = $clog2(BTB_ENTRIES);
	localparam int PW = fsbp_pkg::PC_W;

	fsbp_pkg::in_item_t            in_d;
	fsbp_pkg::btb_ctl_t            btb_ctl;
	logic [fsbp_pkg::LEN_W-1:0]    program_length;
	logic                          accept;

	// stage 1
	logic                          valid_s1;
	logic                          req_s1;
	fsbp_pkg::in_item_t            item_s1;
	logic                          load_done;
	logic                          fetch_go;
	logic                          mispredict;
	logic                          redirect;
	logic [PW-1:0]                 addr_s1;
	logic                          ok_s1;
	logic [PW-1:0]                 ra_tgt;
	logic                          r_valid;
	logic                          r_pred;

	// stage 2
	logic                          valid_s2;
	logic [PW-1:0]                 pc_s2;
	logic                          ok_s2;
	logic                          s2_done;
	logic [fsbp_pkg::WORD_W-1:0]   word;
	logic                          is_beq;
	logic                          f_valid;
	logic                          f_pred;
	logic                          taken_pred;
	logic                          step2;
	logic [PW:0]                   next_pc;
	logic [PW-1:0]                 br_target;
	logic [PW-1:0]                 rb_tgt;

	// architectural state
	logic [PW-1:0]                 pc_q;
	logic                          halted_q;

	assign in_d = fsbp_pkg::in_item_t'(s_tdata);

	fsbp_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.program_length (program_length)
	);

	// handshake: a load leaves stage 1 at once; each item waits for stage 2 to drain
	assign s2_done  = valid_s2 && (!m_tvalid || m_tready);
	assign s_tready = (!valid_s1 || req_s1 == fsbp_pkg::REQ_LOAD) && (!valid_s2 || s2_done);
	assign accept   = s_tvalid && s_tready;

	// stage 1: choose the fetch address
	assign load_done  = valid_s1 && req_s1 == fsbp_pkg::REQ_LOAD;
	assign fetch_go   = valid_s1 && req_s1 == fsbp_pkg::REQ_FETCH;
	assign mispredict = fetch_go && item_s1.resolve_valid && r_valid
		&& (r_pred != item_s1.resolve_taken);
	assign redirect   = mispredict || item_s1.jump_valid;

	always_comb begin
		if (mispredict) begin
			addr_s1 = item_s1.resolve_taken ? ra_tgt : item_s1.resolve_pc + PW'(2);
		end else if (item_s1.jump_valid) begin
			addr_s1 = item_s1.jump_target;
		end else begin
			addr_s1 = pc_q;
		end
	end

	assign ok_s1 = !(halted_q && !redirect) && ({1'b0, addr_s1} < program_length);

	// stage 2: decode the fetched word and pick the next address
	assign is_beq     = word[fsbp_pkg::OPC_LSB +: fsbp_pkg::OPC_W] == fsbp_pkg::OP_BEQ;
	assign taken_pred = is_beq && f_valid && f_pred;
	assign step2      = is_beq && !taken_pred;
	assign next_pc    = {1'b0, pc_s2} + (step2 ? (PW+1)'(2) : (PW+1)'(1));
	// sign extension of the offset has no effect on a 10-bit wrapped target
	assign br_target  = pc_s2 + PW'(1) + word[PW-1:0];

	fsbp_imem #(
		.DEPTH (IMEM_DEPTH)
	) u_imem (
		.clk     (clk),
		.wr_en   (load_done),
		.wr_addr (AW'(item_s1.load_addr)),
		.wr_data (item_s1.load_word),
		.rd_en   (fetch_go),
		.rd_addr (AW'(addr_s1)),
		.rd_data (word)
	);

	assign btb_ctl.rd_a_en    = accept;
	assign btb_ctl.rd_b_en    = fetch_go;
	assign btb_ctl.flip_en    = mispredict;
	assign btb_ctl.flip_taken = item_s1.resolve_taken;
	assign btb_ctl.ins_en     = s2_done && ok_s2 && is_beq && !f_valid;

	fsbp_btb #(
		.ENTRIES (BTB_ENTRIES)
	) u_btb (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (btb_ctl),
		.ra_idx  (in_d.resolve_pc[IW-1:0]),
		.rb_idx  (addr_s1[IW-1:0]),
		.r_idx   (item_s1.resolve_pc[IW-1:0]),
		.f_idx   (pc_s2[IW-1:0]),
		.ins_tgt (br_target),
		.ra_tgt  (ra_tgt),
		.rb_tgt  (rb_tgt),
		.r_valid (r_valid),
		.r_pred  (r_pred),
		.f_valid (f_valid),
		.f_pred  (f_pred)
	);

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (fetch_go) begin
				valid_s2 <= 1'b1;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= s_tuser;
			item_s1 <= in_d;
		end
		if (fetch_go) begin
			pc_s2 <= addr_s1;
			ok_s2 <= ok_s1;
		end
	end

	// fetch address and halt flag; stepping past the top address halts even when
	// a predicted-taken branch supplies the next address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			halted_q <= 1'b0;
		end else if (load_done) begin
			pc_q     <= '0;
			halted_q <= 1'b0;
		end else if (s2_done) begin
			if (!ok_s2) begin
				halted_q <= 1'b1;
			end else if (taken_pred) begin
				pc_q     <= rb_tgt;
				halted_q <= next_pc[PW];
			end else begin
				pc_q     <= next_pc[PW-1:0];
				halted_q <= next_pc[PW];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s2_done) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done) begin
			m_tuser <= ok_s2;
			m_tdata <= fsbp_pkg::out_item_t'{
				pad:         '0,
				instruction: ok_s2 ? word : '0,
				fetched_pc:  ok_s2 ? pc_s2 : fsbp_pkg::PC_ALL_ONES
			};
		end
	end

`ifndef ASSERT_OFF
	// stage 1 and stage 2 never hold items at once
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("stage 1 and stage 2 both occupied");

	// a fetch in stage 1 always moves to stage 2
	a_fetch_advances: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_go |=> valid_s2)
		else $error("fetch item lost between stages");

	// a load and a fetch never update the fetch address together
	a_single_pc_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_done && s2_done))
		else $error("fetch address written twice in one cycle");

	// an invalid result carries the all-ones address and a zero word
	a_invalid_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |->
		(m_tdata[PW-1:0] == fsbp_pkg::PC_ALL_ONES
		&& m_tdata[PW +: fsbp_pkg::WORD_W] == '0))
		else $error("invalid result with stale payload");
`endif

endmodule
